[hdl/lkvt_pkg.sv]
// ----------------------------------------------------------------------------
// lkvt_pkg
// Shared constants, types and helpers of the linear key/value table.
// ----------------------------------------------------------------------------
package lkvt_pkg;

    localparam int CAPACITY   = 256;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (CNT_W > 8) ? CNT_W : 8;

    localparam int DATA_BYTES = 8;
    localparam int KEY_W      = 64;
    localparam int VAL_W      = 64;
    localparam int FUNC_W     = 2;
    localparam int POS_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int MIDX_W     = 8;
    localparam int ENT_W      = 9;
    localparam int BYTES_W    = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_BYTES = 4'd1;

    typedef enum logic [FUNC_W-1:0] {
        FN_FIND,
        FN_SET,
        FN_REMOVE_KEY,
        FN_REMOVE_IDX
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_DUP,
        ST_FULL,
        ST_NOKEY,
        ST_RANGE
    } status_t;

    // byte masks derived from the configuration registers
    typedef struct packed {
        logic [KEY_W-1:0] key_mask;
        logic [VAL_W-1:0] value_mask;
    } cfg_t;

    // one read port and one write port, shared by the key and value memories
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [KEY_W-1:0] wr_key;
        logic [VAL_W-1:0] wr_value;
    } mem_cmd_t;

    // byte counts of zero act as one, above eight as eight
    function automatic logic [KEY_W-1:0] byte_mask(input logic [BYTES_W-1:0] nbytes);
        logic [BYTES_W-1:0] n;
        logic [KEY_W-1:0]   m;
        n = nbytes;
        if (n == '0)
        begin
            n = BYTES_W'(1);
        end
        if (n > BYTES_W'(DATA_BYTES))
        begin
            n = BYTES_W'(DATA_BYTES);
        end
        for (int b = 0; b < DATA_BYTES; b++)
        begin
            m[b*8 +: 8] = (BYTES_W'(b) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

[hdl/lkvt_if.sv]
// ----------------------------------------------------------------------------
// lkvt_if
// Request, response and configuration channels of the key/value table.
// ----------------------------------------------------------------------------
interface lkvt_req_if;
    logic                         valid;
    logic                         ready;
    logic [lkvt_pkg::FUNC_W-1:0]  func;
    logic [lkvt_pkg::KEY_W-1:0]   key;
    logic [lkvt_pkg::VAL_W-1:0]   value;
    logic                         overwrite;
    logic [lkvt_pkg::POS_W-1:0]   position;

    modport source (output valid, func, key, value, overwrite, position,
                    input ready);
    modport sink   (input valid, func, key, value, overwrite, position,
                    output ready);
endinterface

interface lkvt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lkvt_pkg::STATUS_W-1:0] status;
    logic                          found;
    logic [lkvt_pkg::MIDX_W-1:0]   match_index;
    logic [lkvt_pkg::ENT_W-1:0]    entries_now;

    modport source (output valid, status, found, match_index, entries_now,
                    input ready);
    modport sink   (input valid, status, found, match_index, entries_now,
                    output ready);
endinterface

interface lkvt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lkvt_pkg::CFG_IDX_W-1:0]  index;
    logic [lkvt_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/lkvt_ram.sv]
// ----------------------------------------------------------------------------
// lkvt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lkvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/lkvt_ctrl.sv]
// ----------------------------------------------------------------------------
// lkvt_ctrl
// Request sequencer: linear search, set/append, compaction walk, result register.
// ----------------------------------------------------------------------------
module lkvt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  lkvt_pkg::cfg_t     cfg,
    lkvt_req_if.sink           req,
    lkvt_rsp_if.source         rsp,
    output lkvt_pkg::mem_cmd_t mem,
    input  logic [lkvt_pkg::KEY_W-1:0] rd_key,
    input  logic [lkvt_pkg::VAL_W-1:0] rd_value
);
    import lkvt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t           state_reg,       state_next;
    func_t            func_reg,        func_next;
    logic [KEY_W-1:0] key_reg,         key_next;
    logic [VAL_W-1:0] value_reg,       value_next;
    logic             repl_reg,        repl_next;
    logic [CNT_W-1:0] scan_reg,        scan_next;
    logic             pend_reg,        pend_next;
    logic [IDX_W-1:0] pend_idx_reg,    pend_idx_next;
    logic [CNT_W-1:0] count_reg,       count_next;
    status_t          res_status_reg,  res_status_next;
    logic             res_found_reg,   res_found_next;
    logic [IDX_W-1:0] res_idx_reg,     res_idx_next;
    logic             out_valid_reg,   out_valid_next;
    status_t          out_status_reg,  out_status_next;
    logic             out_found_reg,   out_found_next;
    logic [IDX_W-1:0] out_idx_reg,     out_idx_next;
    logic [CNT_W-1:0] out_entries_reg, out_entries_next;

    logic hit;
    logic full;
    logic more;

    // the entry read last cycle matches under the current key mask
    assign hit  = pend_reg && (((rd_key ^ key_reg) & cfg.key_mask) == '0);
    assign full = (count_reg == CNT_W'(CAPACITY));
    assign more = (scan_reg < count_reg);

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.match_index = MIDX_W'(out_idx_reg);
    assign rsp.entries_now = ENT_W'(out_entries_reg);

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        key_next         = key_reg;
        value_next       = value_reg;
        repl_next        = repl_reg;
        scan_next        = scan_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        count_next       = count_reg;
        res_status_next  = res_status_reg;
        res_found_next   = res_found_reg;
        res_idx_next     = res_idx_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_found_next   = out_found_reg;
        out_idx_next     = out_idx_reg;
        out_entries_next = out_entries_reg;

        mem          = '0;
        mem.rd_addr  = scan_reg[IDX_W-1:0];
        mem.wr_key   = key_reg & cfg.key_mask;
        mem.wr_value = value_reg & cfg.value_mask;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = func_t'(req.func);
                    key_next   = req.key;
                    value_next = req.value;
                    repl_next  = req.overwrite;
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    if (func_t'(req.func) == FN_REMOVE_IDX)
                    begin
                        res_found_next = 1'b0;
                        if (CMP_W'(req.position) >= CMP_W'(count_reg))
                        begin
                            res_status_next = ST_RANGE;
                            res_idx_next    = '0;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            res_status_next = ST_OK;
                            res_idx_next    = IDX_W'(req.position);
                            scan_next       = CNT_W'(req.position) + CNT_W'(1);
                            state_next      = S_SHIFT;
                        end
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    pend_next       = 1'b0;
                    res_status_next = ST_OK;
                    res_found_next  = 1'b1;
                    res_idx_next    = pend_idx_reg;
                    state_next      = S_DONE;
                    unique case (func_reg)
                        FN_FIND:
                        begin
                        end
                        FN_SET:
                        begin
                            if (repl_reg)
                            begin
                                mem.wr_en   = 1'b1;
                                mem.wr_addr = pend_idx_reg;
                            end
                            else
                            begin
                                res_status_next = ST_DUP;
                            end
                        end
                        FN_REMOVE_KEY:
                        begin
                            scan_next  = CNT_W'(pend_idx_reg) + CNT_W'(1);
                            state_next = S_SHIFT;
                        end
                        FN_REMOVE_IDX:
                        begin
                        end
                    endcase
                end
                else if (more)
                begin
                    mem.rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end
                else
                begin
                    // every entry checked, no match
                    pend_next       = 1'b0;
                    res_found_next  = 1'b0;
                    res_idx_next    = '0;
                    res_status_next = ST_NOKEY;
                    state_next      = S_DONE;
                    if (func_reg == FN_SET)
                    begin
                        if (full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            mem.wr_en       = 1'b1;
                            mem.wr_addr     = count_reg[IDX_W-1:0];
                            res_status_next = ST_OK;
                            res_idx_next    = count_reg[IDX_W-1:0];
                            count_next      = count_reg + CNT_W'(1);
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                // entry read last cycle moves down one place
                if (pend_reg)
                begin
                    mem.wr_en    = 1'b1;
                    mem.wr_addr  = pend_idx_reg - IDX_W'(1);
                    mem.wr_key   = rd_key;
                    mem.wr_value = rd_value;
                end
                if (more)
                begin
                    mem.rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_found_next   = res_found_reg;
                    out_idx_next     = res_idx_reg;
                    out_entries_next = count_reg;
                    state_next       = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            func_reg        <= FN_FIND;
            key_reg         <= '0;
            value_reg       <= '0;
            repl_reg        <= 1'b0;
            scan_reg        <= '0;
            pend_reg        <= 1'b0;
            pend_idx_reg    <= '0;
            count_reg       <= '0;
            res_status_reg  <= ST_OK;
            res_found_reg   <= 1'b0;
            res_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_OK;
            out_found_reg   <= 1'b0;
            out_idx_reg     <= '0;
            out_entries_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            func_reg        <= func_next;
            key_reg         <= key_next;
            value_reg       <= value_next;
            repl_reg        <= repl_next;
            scan_reg        <= scan_next;
            pend_reg        <= pend_next;
            pend_idx_reg    <= pend_idx_next;
            count_reg       <= count_next;
            res_status_reg  <= res_status_next;
            res_found_reg   <= res_found_next;
            res_idx_reg     <= res_idx_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_found_reg   <= out_found_next;
            out_idx_reg     <= out_idx_next;
            out_entries_reg <= out_entries_next;
        end
    end

endmodule

[hdl/linear_key_value_table.sv]
// ----------------------------------------------------------------------------
// linear_key_value_table
// Insertion-ordered key/value table with find, set and two kinds of removal.
// ----------------------------------------------------------------------------
// Keys and values live in two CAPACITY-deep RAMs with registered reads; one
// sequencer walks them through a single read port, one entry per cycle. A find
// or set reads the entries in order from index zero until the matching entry
// or, when the key is absent, until the count. A remove by key adds a
// compaction walk that moves every later entry down one place; a remove by
// index does only that walk, from the given position, and one out of range
// goes straight to its result. The longest item is a remove by key on a full
// table, and a stalled earlier result can hold any item back further. One
// item is worked on at a time; a finished result waits in an output register
// while the next item is taken. The RAMs need no clearing after reset: only
// entries below the count are ever read. key_bytes and value_bytes may be
// written only while no item is in flight.
module linear_key_value_table (
    input logic clk,
    input logic rst_n,
    lkvt_req_if.sink   req,
    lkvt_rsp_if.source rsp,
    lkvt_cfg_if.sink   cfg
);
    import lkvt_pkg::*;

    logic [BYTES_W-1:0] key_bytes_reg,   key_bytes_next;
    logic [BYTES_W-1:0] value_bytes_reg, value_bytes_next;

    cfg_t             masks;
    mem_cmd_t         mem;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_value;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        key_bytes_next   = key_bytes_reg;
        value_bytes_next = value_bytes_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_KEY_BYTES:   key_bytes_next   = cfg.data;
                REG_VALUE_BYTES: value_bytes_next = cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg   <= BYTES_W'(DATA_BYTES);
            value_bytes_reg <= BYTES_W'(DATA_BYTES);
        end
        else
        begin
            key_bytes_reg   <= key_bytes_next;
            value_bytes_reg <= value_bytes_next;
        end
    end

    assign masks.key_mask   = byte_mask(key_bytes_reg);
    assign masks.value_mask = VAL_W'(byte_mask(value_bytes_reg));

    lkvt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (masks),
        .req      (req),
        .rsp      (rsp),
        .mem      (mem),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    lkvt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (mem.wr_en),
        .wr_addr (mem.wr_addr),
        .wr_data (mem.wr_key),
        .rd_en   (mem.rd_en),
        .rd_addr (mem.rd_addr),
        .rd_data (rd_key)
    );

    lkvt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (mem.wr_en),
        .wr_addr (mem.wr_addr),
        .wr_data (mem.wr_value),
        .rd_en   (mem.rd_en),
        .rd_addr (mem.rd_addr),
        .rd_data (rd_value)
    );

endmodule

[hdl/lkvt_checker.sv]
// ----------------------------------------------------------------------------
// lkvt_checker
// Port-level assertions for the key/value table, bound to the top level.
// ----------------------------------------------------------------------------
module lkvt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [lkvt_pkg::STATUS_W-1:0] rsp_status,
    input logic                          rsp_found,
    input logic [lkvt_pkg::MIDX_W-1:0]   rsp_match_index,
    input logic [lkvt_pkg::ENT_W-1:0]    rsp_entries_now
);
    import lkvt_pkg::*;

    logic [1:0]       outstanding_reg,  outstanding_next;
    logic [ENT_W-1:0] last_entries_reg, last_entries_next;
    logic             req_acc;
    logic             rsp_acc;
    logic             failed;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;
    assign failed  = (rsp_status == ST_DUP) || (rsp_status == ST_FULL) ||
                     (rsp_status == ST_NOKEY) || (rsp_status == ST_RANGE);

    always_comb
    begin
        outstanding_next  = outstanding_reg + 2'(req_acc) - 2'(rsp_acc);
        last_entries_next = rsp_acc ? rsp_entries_now : last_entries_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg  <= '0;
            last_entries_reg <= '0;
        end
        else
        begin
            outstanding_reg  <= outstanding_next;
            last_entries_reg <= last_entries_next;
        end
    end

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid &&
            $stable({rsp_status, rsp_found, rsp_match_index, rsp_entries_now}))
        else $error("result changed while stalled");

    // no result without an item behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outstanding_reg != 2'd0)
        else $error("result without an accepted item");

    // at most one item in work and one result waiting
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |-> outstanding_reg < 2'd2)
        else $error("too many items in flight");

    // a failed request leaves the entry count unchanged
    a_fail_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_acc && failed |-> rsp_entries_now == last_entries_reg)
        else $error("failed request changed the entry count");

endmodule

bind linear_key_value_table lkvt_checker u_lkvt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_found       (rsp.found),
    .rsp_match_index (rsp.match_index),
    .rsp_entries_now (rsp.entries_now)
);
